@@ hdl/aabb_overlap_side_resolver_defines.svh @@
// Assertion macros used by the checker file.
`ifndef AABB_OVERLAP_SIDE_RESOLVER_DEFINES_SVH
`define AABB_OVERLAP_SIDE_RESOLVER_DEFINES_SVH

// Clocked property, masked while reset is held.
`define AOSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked property that also holds during reset.
`define AOSR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hdl/aosr_pkg.sv @@
`default_nettype none

package aosr_pkg;

    // Result side codes.
    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_TOP    = 3'd1,
        SIDE_BOTTOM = 3'd2,
        SIDE_RIGHT  = 3'd3,
        SIDE_LEFT   = 3'd4
    } side_t;

    // Width of the reported offsets.
    localparam int OFFSET_BITS = 26;

    // Edges are kept in Q.17; offsets are Q.8.
    localparam int FRAC_DROP = 9;
    localparam int ROUND_HALF = 1 << (FRAC_DROP - 1);

endpackage

`default_nettype wire

@@ hdl/aosr_round_sat.sv @@
`default_nettype none

// Round a Q.17 distance to Q.8 (halves toward plus infinity) and clamp to the
// offset range.
module aosr_round_sat #(
    parameter int DIST_BITS = 35
) (
    input  wire logic signed [DIST_BITS-1:0]             dist_in,
    output logic signed [aosr_pkg::OFFSET_BITS-1:0]      offset
);

    localparam int Q_BITS = DIST_BITS + 1 - aosr_pkg::FRAC_DROP;
    localparam int EXT_BITS =
        ((Q_BITS > aosr_pkg::OFFSET_BITS) ? Q_BITS : aosr_pkg::OFFSET_BITS) + 1;
    localparam logic signed [EXT_BITS-1:0] Q_HI =
        EXT_BITS'((64'sd1 <<< (aosr_pkg::OFFSET_BITS - 1)) - 64'sd1);
    localparam logic signed [EXT_BITS-1:0] Q_LO = -Q_HI - EXT_BITS'(1);

    logic signed [DIST_BITS:0]   biased;
    logic signed [EXT_BITS-1:0]  q_ext;

    assign biased = (DIST_BITS + 1)'(dist_in) +
                    $signed((DIST_BITS + 1)'(aosr_pkg::ROUND_HALF));
    assign q_ext  = EXT_BITS'($signed(biased[DIST_BITS:aosr_pkg::FRAC_DROP]));

    always_comb begin
        if (q_ext > Q_HI) begin
            offset = Q_HI[aosr_pkg::OFFSET_BITS-1:0];
        end else if (q_ext < Q_LO) begin
            offset = Q_LO[aosr_pkg::OFFSET_BITS-1:0];
        end else begin
            offset = q_ext[aosr_pkg::OFFSET_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hdl/aabb_overlap_side_resolver.sv @@
// Channel   Ports                                          Direction
// s_        s_valid/s_ready, two boxes (center, w, h, sc)  in  : one request per box pair
// m_        m_valid/m_ready, m_side, m_offset_x/_y         out : one result per request
//
// One request is accepted every cycle while results are taken. Five registers sit in
// line (input register, multiply, edge distances, pairwise minimum, final pick with
// rounding into the result register); m_valid rises when a request reaches the
// result register, and the result leaves at the first edge where m_ready is high.
// Reset (aresetn low at a clock edge) empties every stage; payload is not reset.
// A stall on m_ready backs up stage by stage; empty stages still fill, so
// s_ready stays high until every stage holds a request.
`default_nettype none

module aabb_overlap_side_resolver #(
    parameter int COORD_BITS = 24,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [COORD_BITS-1:0]          s_self_pos_x,
    input  wire logic signed [COORD_BITS-1:0]          s_self_pos_y,
    input  wire logic        [SIZE_BITS-1:0]           s_self_width,
    input  wire logic        [SIZE_BITS-1:0]           s_self_height,
    input  wire logic        [SIZE_BITS-1:0]           s_self_scale,
    input  wire logic signed [COORD_BITS-1:0]          s_other_pos_x,
    input  wire logic signed [COORD_BITS-1:0]          s_other_pos_y,
    input  wire logic        [SIZE_BITS-1:0]           s_other_width,
    input  wire logic        [SIZE_BITS-1:0]           s_other_height,
    input  wire logic        [SIZE_BITS-1:0]           s_other_scale,

    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic             [2:0]                     m_side,
    output logic signed [aosr_pkg::OFFSET_BITS-1:0]    m_offset_x,
    output logic signed [aosr_pkg::OFFSET_BITS-1:0]    m_offset_y
);

    // Product of size and scale is the half extent in Q.17.
    localparam int PROD_BITS = 2 * SIZE_BITS;
    // Center difference in Q.8 and in Q.17.
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int DQ17_BITS = DIFF_BITS + aosr_pkg::FRAC_DROP;
    // Edge distance: center difference plus or minus summed half extents.
    localparam int DIST_BITS =
        ((DQ17_BITS > PROD_BITS + 1) ? DQ17_BITS : PROD_BITS + 1) + 1;

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its successor moves.
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic en0, en1, en2, en3, en4;

    assign en4 = !out_valid_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;

    assign s_ready = en0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en0) begin
                v0_reg <= s_valid;
            end
            if (en1) begin
                v1_reg <= v0_reg;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register.
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] spx_reg, spy_reg, opx_reg, opy_reg;
    logic        [SIZE_BITS-1:0]  sw_reg, sh_reg, ssc_reg, ow_reg, oh_reg, osc_reg;

    always_ff @(posedge aclk) begin
        if (en0 && s_valid) begin
            spx_reg <= s_self_pos_x;
            spy_reg <= s_self_pos_y;
            sw_reg  <= s_self_width;
            sh_reg  <= s_self_height;
            ssc_reg <= s_self_scale;
            opx_reg <= s_other_pos_x;
            opy_reg <= s_other_pos_y;
            ow_reg  <= s_other_width;
            oh_reg  <= s_other_height;
            osc_reg <= s_other_scale;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: half extents (one multiplier each) and center differences.
    // ------------------------------------------------------------------
    logic signed [DIFF_BITS-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic [PROD_BITS-1:0] shw_next, shh_next, ohw_next, ohh_next;
    logic [PROD_BITS-1:0] shw_reg, shh_reg, ohw_reg, ohh_reg;

    assign dx_next  = DIFF_BITS'(opx_reg) - DIFF_BITS'(spx_reg);
    assign dy_next  = DIFF_BITS'(opy_reg) - DIFF_BITS'(spy_reg);
    assign shw_next = PROD_BITS'(sw_reg) * PROD_BITS'(ssc_reg);
    assign shh_next = PROD_BITS'(sh_reg) * PROD_BITS'(ssc_reg);
    assign ohw_next = PROD_BITS'(ow_reg) * PROD_BITS'(osc_reg);
    assign ohh_next = PROD_BITS'(oh_reg) * PROD_BITS'(osc_reg);

    always_ff @(posedge aclk) begin
        if (en1 && v0_reg) begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            shw_reg <= shw_next;
            shh_reg <= shh_next;
            ohw_reg <= ohw_next;
            ohh_reg <= ohh_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: edge distance magnitudes. With hx, hy the summed half extents:
    //   top = dy - hy, bottom = dy + hy, right = dx + hx, left = dx - hx.
    // Keep -top and -left so that all four are non-negative exactly when
    // the boxes overlap (touching included); a negative one means apart.
    // ------------------------------------------------------------------
    logic signed [DQ17_BITS-1:0] dx_q17, dy_q17;
    logic signed [DIST_BITS-1:0] dx_ext, dy_ext, hx_ext, hy_ext;
    logic signed [DIST_BITS-1:0] mt_next, mb_next, mr_next, ml_next;
    logic signed [DIST_BITS-1:0] mt_reg, mb_reg, mr_reg, ml_reg;
    logic                        apart_next, apart2_reg;

    assign dx_q17 = {dx_reg, {aosr_pkg::FRAC_DROP{1'b0}}};
    assign dy_q17 = {dy_reg, {aosr_pkg::FRAC_DROP{1'b0}}};
    assign dx_ext = DIST_BITS'(dx_q17);
    assign dy_ext = DIST_BITS'(dy_q17);
    assign hx_ext = $signed(DIST_BITS'(shw_reg) + DIST_BITS'(ohw_reg));
    assign hy_ext = $signed(DIST_BITS'(shh_reg) + DIST_BITS'(ohh_reg));

    assign mt_next = hy_ext - dy_ext;
    assign mb_next = dy_ext + hy_ext;
    assign mr_next = dx_ext + hx_ext;
    assign ml_next = hx_ext - dx_ext;

    assign apart_next = mt_next[DIST_BITS-1] | mb_next[DIST_BITS-1] |
                        mr_next[DIST_BITS-1] | ml_next[DIST_BITS-1];

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            mt_reg     <= mt_next;
            mb_reg     <= mb_next;
            mr_reg     <= mr_next;
            ml_reg     <= ml_next;
            apart2_reg <= apart_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: minimum within each axis. On a tie the first of the pair
    // (top over bottom, right over left) wins.
    // ------------------------------------------------------------------
    logic signed [DIST_BITS-1:0] magy_next, disty_next, magx_next, distx_next;
    logic signed [DIST_BITS-1:0] magy_reg, disty_reg, magx_reg, distx_reg;
    aosr_pkg::side_t             sidey_next, sidex_next, sidey_reg, sidex_reg;
    logic                        apart3_reg;

    always_comb begin
        if (mb_reg < mt_reg) begin
            magy_next  = mb_reg;
            disty_next = mb_reg;
            sidey_next = aosr_pkg::SIDE_BOTTOM;
        end else begin
            magy_next  = mt_reg;
            disty_next = -mt_reg;
            sidey_next = aosr_pkg::SIDE_TOP;
        end
        if (ml_reg < mr_reg) begin
            magx_next  = ml_reg;
            distx_next = -ml_reg;
            sidex_next = aosr_pkg::SIDE_LEFT;
        end else begin
            magx_next  = mr_reg;
            distx_next = mr_reg;
            sidex_next = aosr_pkg::SIDE_RIGHT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            magy_reg   <= magy_next;
            disty_reg  <= disty_next;
            sidey_reg  <= sidey_next;
            magx_reg   <= magx_next;
            distx_reg  <= distx_next;
            sidex_reg  <= sidex_next;
            apart3_reg <= apart2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pick the axis (vertical wins ties), round, clamp, and drive
    // the result register. Separated boxes report no side and zero offsets.
    // ------------------------------------------------------------------
    logic                                        pick_x;
    logic signed [DIST_BITS-1:0]                 best_dist;
    logic signed [aosr_pkg::OFFSET_BITS-1:0]     best_off;
    aosr_pkg::side_t                             side_next, side_reg;
    logic signed [aosr_pkg::OFFSET_BITS-1:0]     offx_next, offy_next, offx_reg, offy_reg;

    assign pick_x    = magx_reg < magy_reg;
    assign best_dist = pick_x ? distx_reg : disty_reg;

    aosr_round_sat #(
        .DIST_BITS (DIST_BITS)
    ) u_round_sat (
        .dist_in (best_dist),
        .offset  (best_off)
    );

    always_comb begin
        side_next = aosr_pkg::SIDE_NONE;
        offx_next = '0;
        offy_next = '0;
        if (!apart3_reg) begin
            if (pick_x) begin
                side_next = sidex_reg;
                offx_next = best_off;
            end else begin
                side_next = sidey_reg;
                offy_next = best_off;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en4 && v3_reg) begin
            side_reg <= side_next;
            offx_reg <= offx_next;
            offy_reg <= offy_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_side     = side_reg;
    assign m_offset_x = offx_reg;
    assign m_offset_y = offy_reg;

endmodule

`default_nettype wire

@@ hdl/aosr_checker.sv @@
`default_nettype none

`include "aabb_overlap_side_resolver_defines.svh"

module aosr_checker (
    input wire logic                                   aclk,
    input wire logic                                   aresetn,
    input wire logic                                   s_ready,
    input wire logic                                   m_valid,
    input wire logic                                   m_ready,
    input wire logic        [2:0]                      m_side,
    input wire logic signed [aosr_pkg::OFFSET_BITS-1:0] m_offset_x,
    input wire logic signed [aosr_pkg::OFFSET_BITS-1:0] m_offset_y
);

    logic side_none;
    logic side_vert;
    logic side_horz;

    assign side_none = (m_side == aosr_pkg::SIDE_NONE);
    assign side_vert = (m_side == aosr_pkg::SIDE_TOP) || (m_side == aosr_pkg::SIDE_BOTTOM);
    assign side_horz = (m_side == aosr_pkg::SIDE_RIGHT) || (m_side == aosr_pkg::SIDE_LEFT);

    // Hold a stalled result.
    `AOSR_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_side) && $stable(m_offset_x) && $stable(m_offset_y), "stalled result changed")

    // Drop every result on reset.
    `AOSR_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

    // An empty result register never blocks the input side.
    `AOSR_ASSERT(a_ready_when_empty, !m_valid |-> s_ready, "input stalled with no result pending")

    // Only the reported axis carries an offset.
    `AOSR_ASSERT(a_offset_axis, m_valid |-> (side_none && m_offset_x == 0 && m_offset_y == 0) || (side_vert && m_offset_x == 0) || (side_horz && m_offset_y == 0), "offset on wrong axis")

endmodule

bind aabb_overlap_side_resolver aosr_checker u_aosr_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_side     (m_side),
    .m_offset_x (m_offset_x),
    .m_offset_y (m_offset_y)
);

`default_nettype wire

@@ verif/aabb_overlap_side_resolver_tb.sv @@
`timescale 1ns / 100ps

module aabb_overlap_side_resolver_tb;

    localparam int COORD_BITS = 24;
    localparam int SIZE_BITS  = 16;
    localparam int OFFSET_BITS = aosr_pkg::OFFSET_BITS;
    // Runaway guard.
    localparam int CYCLE_LIMIT = 400000;
    // Receiver hold-off long enough to fill every pipeline stage.
    localparam int HOLD_OFF_CYCLES = 80;

    // One request: a pair of boxes.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] self_pos_x;
        logic signed [COORD_BITS-1:0] self_pos_y;
        logic        [SIZE_BITS-1:0]  self_width;
        logic        [SIZE_BITS-1:0]  self_height;
        logic        [SIZE_BITS-1:0]  self_scale;
        logic signed [COORD_BITS-1:0] other_pos_x;
        logic signed [COORD_BITS-1:0] other_pos_y;
        logic        [SIZE_BITS-1:0]  other_width;
        logic        [SIZE_BITS-1:0]  other_height;
        logic        [SIZE_BITS-1:0]  other_scale;
    } box_pair_t;

    // One result: the contact side and its signed penetration.
    typedef struct packed {
        aosr_pkg::side_t               side;
        logic signed [OFFSET_BITS-1:0] off_x;
        logic signed [OFFSET_BITS-1:0] off_y;
    } contact_t;

    // Predict the contact of each accepted request and match results in order.
    class contact_scoreboard;
        contact_t expected_contacts[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // Round an exact Q.17 distance to Q.8, halves toward plus infinity, and clamp.
        function logic signed [OFFSET_BITS-1:0] round_to_offset(longint d);
            longint q;
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (OFFSET_BITS - 1)) - 1;
            lo = -(longint'(1) <<< (OFFSET_BITS - 1));
            q = (d + aosr_pkg::ROUND_HALF) >>> aosr_pkg::FRAC_DROP;
            if (q > hi) q = hi;
            if (q < lo) q = lo;
            return q[OFFSET_BITS-1:0];
        endfunction

        function contact_t resolve_contact(box_pair_t p);
            longint          sx, sy, ox, oy;
            longint          shw, shh, ohw, ohh;
            longint          s_minx, s_maxx, s_miny, s_maxy;
            longint          o_minx, o_maxx, o_miny, o_maxy;
            longint          edge_dist[4];
            longint          mags[4];
            int              best;
            aosr_pkg::side_t side_of[4];
            contact_t        c;
            side_of = '{aosr_pkg::SIDE_TOP, aosr_pkg::SIDE_BOTTOM,
                        aosr_pkg::SIDE_RIGHT, aosr_pkg::SIDE_LEFT};
            // Centers go from Q.8 to Q.17; size times scale is already the half extent in Q.17.
            sx  = longint'(p.self_pos_x) * 512;
            sy  = longint'(p.self_pos_y) * 512;
            ox  = longint'(p.other_pos_x) * 512;
            oy  = longint'(p.other_pos_y) * 512;
            shw = longint'(p.self_width) * longint'(p.self_scale);
            shh = longint'(p.self_height) * longint'(p.self_scale);
            ohw = longint'(p.other_width) * longint'(p.other_scale);
            ohh = longint'(p.other_height) * longint'(p.other_scale);
            s_minx = sx - shw;  s_maxx = sx + shw;
            s_miny = sy - shh;  s_maxy = sy + shh;
            o_minx = ox - ohw;  o_maxx = ox + ohw;
            o_miny = oy - ohh;  o_maxy = oy + ohh;
            c.side  = aosr_pkg::SIDE_NONE;
            c.off_x = '0;
            c.off_y = '0;
            // Touching edges still count as overlap.
            if (s_maxx < o_minx || o_maxx < s_minx || s_maxy < o_miny || o_maxy < s_miny)
                return c;
            edge_dist[0] = o_miny - s_maxy;
            edge_dist[1] = o_maxy - s_miny;
            edge_dist[2] = o_maxx - s_minx;
            edge_dist[3] = o_minx - s_maxx;
            foreach (edge_dist[i]) mags[i] = (edge_dist[i] < 0) ? -edge_dist[i] : edge_dist[i];
            // Strict compare keeps the earlier side on a tie.
            best = 0;
            for (int i = 1; i < 4; i++)
                if (mags[i] < mags[best]) best = i;
            c.side = side_of[best];
            if (best < 2)
                c.off_y = round_to_offset(edge_dist[best]);
            else
                c.off_x = round_to_offset(edge_dist[best]);
            return c;
        endfunction

        function void note_request(box_pair_t p);
            expected_contacts.push_back(resolve_contact(p));
        endfunction

        function void check_result(logic [2:0] side, logic signed [OFFSET_BITS-1:0] off_x,
                                   logic signed [OFFSET_BITS-1:0] off_y);
            contact_t want;
            if (expected_contacts.size() == 0) begin
                $display("%0t: unexpected result side %0d offset_x %0d offset_y %0d",
                         $time, side, off_x, off_y);
                errors++;
                return;
            end
            want = expected_contacts.pop_front();
            if (side !== want.side) begin
                $display("%0t: side expected %0d actual %0d", $time, want.side, side);
                errors++;
            end
            if (off_x !== want.off_x) begin
                $display("%0t: offset_x expected %0d actual %0d", $time, want.off_x, off_x);
                errors++;
            end
            if (off_y !== want.off_y) begin
                $display("%0t: offset_y expected %0d actual %0d", $time, want.off_y, off_y);
                errors++;
            end
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid = 1'b0;
    logic                          s_ready;
    box_pair_t                     s_pair  = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [2:0]                    m_side;
    logic signed [OFFSET_BITS-1:0] m_offset_x;
    logic signed [OFFSET_BITS-1:0] m_offset_y;

    // calm: no idling on either side. hold_off_pending: ask the receiver for a long stall.
    logic calm             = 1'b0;
    logic hold_off_pending = 1'b0;
    int   stall_left       = 0;
    int   cycle_count      = 0;

    contact_scoreboard sb = new();

    aabb_overlap_side_resolver #(
        .COORD_BITS(COORD_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_self_pos_x  (s_pair.self_pos_x),
        .s_self_pos_y  (s_pair.self_pos_y),
        .s_self_width  (s_pair.self_width),
        .s_self_height (s_pair.self_height),
        .s_self_scale  (s_pair.self_scale),
        .s_other_pos_x (s_pair.other_pos_x),
        .s_other_pos_y (s_pair.other_pos_y),
        .s_other_width (s_pair.other_width),
        .s_other_height(s_pair.other_height),
        .s_other_scale (s_pair.other_scale),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_side        (m_side),
        .m_offset_x    (m_offset_x),
        .m_offset_y    (m_offset_y)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("aabb_overlap_side_resolver_tb failed");
            $finish;
        end
    end

    // Receiver: drive m_ready at the falling edge. A pending hold-off takes priority
    // and keeps m_ready low for a counted stretch while the sender keeps pushing.
    always @(negedge aclk) begin
        if (hold_off_pending) begin
            hold_off_pending <= 1'b0;
            stall_left = HOLD_OFF_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= 12);
        end
    end

    // Sample results at the rising edge, where both handshake signals are settled.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_side, m_offset_x, m_offset_y);
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    // Idle cycles drop valid for whole cycles, never between two requests in one step.
    task automatic send_pair(box_pair_t p);
        while (!calm && $urandom_range(99, 0) < 12) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pair  <= p;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(p);
        @(negedge aclk);
    endtask

    function automatic box_pair_t make_pair(
        int sx, int sy, int sw, int sh, int ss, int ox, int oy, int ow, int oh, int os);
        box_pair_t p;
        p.self_pos_x   = sx[COORD_BITS-1:0];
        p.self_pos_y   = sy[COORD_BITS-1:0];
        p.self_width   = sw[SIZE_BITS-1:0];
        p.self_height  = sh[SIZE_BITS-1:0];
        p.self_scale   = ss[SIZE_BITS-1:0];
        p.other_pos_x  = ox[COORD_BITS-1:0];
        p.other_pos_y  = oy[COORD_BITS-1:0];
        p.other_width  = ow[SIZE_BITS-1:0];
        p.other_height = oh[SIZE_BITS-1:0];
        p.other_scale  = os[SIZE_BITS-1:0];
        return p;
    endfunction

    // Random request. Most pairs have nearby centers; the rest are raw noise,
    // exactly touching boxes, and tiny boxes where equal distances are common.
    function automatic box_pair_t random_pair();
        box_pair_t p;
        int        mode;
        int        k;
        int        dx, dy;
        int        reach;
        mode = $urandom_range(99, 0);
        p.self_pos_x   = COORD_BITS'($urandom);
        p.self_pos_y   = COORD_BITS'($urandom);
        p.self_width   = SIZE_BITS'($urandom);
        p.self_height  = SIZE_BITS'($urandom);
        p.self_scale   = SIZE_BITS'($urandom);
        p.other_pos_x  = COORD_BITS'($urandom);
        p.other_pos_y  = COORD_BITS'($urandom);
        p.other_width  = SIZE_BITS'($urandom);
        p.other_height = SIZE_BITS'($urandom);
        p.other_scale  = SIZE_BITS'($urandom);
        if (mode < 15) begin
            // noise: leave every field fully random
        end else if (mode < 30) begin
            // Scale 2.0 makes each half extent equal to the size in Q.8 units, so an
            // offset of the summed sizes puts facing edges of the boxes exactly together.
            p.self_width   = SIZE_BITS'($urandom_range(16'h3FFF, 0));
            p.self_height  = SIZE_BITS'($urandom_range(16'h3FFF, 0));
            p.other_width  = SIZE_BITS'($urandom_range(16'h3FFF, 0));
            p.other_height = SIZE_BITS'($urandom_range(16'h3FFF, 0));
            p.self_scale   = 16'h0200;
            p.other_scale  = 16'h0200;
            if ($urandom_range(1, 0)) begin
                dx = int'(p.self_width) + int'(p.other_width);
                reach = int'(p.self_height) + int'(p.other_height);
                dy = int'($urandom_range(2 * reach, 0)) - reach;
            end else begin
                dy = int'(p.self_height) + int'(p.other_height);
                reach = int'(p.self_width) + int'(p.other_width);
                dx = int'($urandom_range(2 * reach, 0)) - reach;
            end
            if ($urandom_range(1, 0)) dx = -dx;
            if ($urandom_range(1, 0)) dy = -dy;
            p.other_pos_x = p.self_pos_x + dx[COORD_BITS-1:0];
            p.other_pos_y = p.self_pos_y + dy[COORD_BITS-1:0];
        end else if (mode < 45) begin
            // Tiny boxes near a common base: ties between sides show up often.
            p.self_width   = SIZE_BITS'($urandom_range(15, 0));
            p.self_height  = SIZE_BITS'($urandom_range(15, 0));
            p.other_width  = SIZE_BITS'($urandom_range(15, 0));
            p.other_height = SIZE_BITS'($urandom_range(15, 0));
            p.self_scale   = SIZE_BITS'($urandom_range(128, 0));
            p.other_scale  = SIZE_BITS'($urandom_range(128, 0));
            p.other_pos_x  = p.self_pos_x + COORD_BITS'($urandom_range(15, 0));
            p.other_pos_y  = p.self_pos_y + COORD_BITS'($urandom_range(15, 0));
            p.self_pos_x   = p.self_pos_x + COORD_BITS'($urandom_range(15, 0));
            p.self_pos_y   = p.self_pos_y + COORD_BITS'($urandom_range(15, 0));
        end else begin
            // Nearby centers with a random reach; full-range sizes.
            if ($urandom_range(3, 0) != 0) begin
                p.self_scale  = SIZE_BITS'($urandom_range(16'h03FF, 0));
                p.other_scale = SIZE_BITS'($urandom_range(16'h03FF, 0));
            end
            k  = $urandom_range(22, 4);
            dx = int'($urandom_range(1 << k, 0));
            dy = int'($urandom_range(1 << k, 0));
            if ($urandom_range(1, 0)) dx = -dx;
            if ($urandom_range(1, 0)) dy = -dy;
            p.other_pos_x = p.self_pos_x + dx[COORD_BITS-1:0];
            p.other_pos_y = p.self_pos_y + dy[COORD_BITS-1:0];
        end
        return p;
    endfunction

    box_pair_t directed[$];

    initial begin
        // Unit boxes (size 1.0, scale 1.0) at the origin, the other shifted by 0.75.
        directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));           // two points, same spot
        directed.push_back(make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));           // two points apart
        directed.push_back(make_pair(0, 0, 256, 256, 256, 1000, 0, 256, 256, 256)); // far apart
        directed.push_back(make_pair(0, 0, 256, 256, 256, 0, 192, 256, 256, 256));  // top
        directed.push_back(make_pair(0, 0, 256, 256, 256, 0, -192, 256, 256, 256)); // bottom
        directed.push_back(make_pair(0, 0, 256, 256, 256, -192, 0, 256, 256, 256)); // right
        directed.push_back(make_pair(0, 0, 256, 256, 256, 192, 0, 256, 256, 256));  // left
        // Ties: top over bottom, bottom over right, right over left.
        directed.push_back(make_pair(0, 0, 512, 256, 256, 0, 0, 512, 256, 256));
        directed.push_back(make_pair(0, 0, 256, 256, 256, -192, -192, 256, 256, 256));
        directed.push_back(make_pair(0, 0, 256, 512, 256, 0, 0, 256, 512, 256));
        // Exact touch on x and on y, then one Q.8 step beyond the touch.
        directed.push_back(make_pair(0, 0, 256, 1024, 512, 512, 0, 256, 1024, 512));
        directed.push_back(make_pair(0, 0, 1024, 256, 512, 0, -512, 1024, 256, 512));
        directed.push_back(make_pair(0, 0, 256, 1024, 512, 513, 0, 256, 1024, 512));
        // Exact half: +0.5 LSB rounds up; then the boxes shifted one Q.8 step either way, now apart.
        directed.push_back(make_pair(0, 0, 1, 256, 128, 0, 0, 1, 256, 128));
        directed.push_back(make_pair(0, 0, 1, 256, 128, 1, 0, 1, 256, 128));
        directed.push_back(make_pair(0, 0, 1, 256, 128, -1, 0, 1, 256, 128));
        // Extremes of centers, sizes and scales.
        directed.push_back(make_pair(32'h7FFFFF, 32'h7FFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                                     32'h800000, 32'h800000, 32'hFFFF, 32'hFFFF, 32'hFFFF));
        directed.push_back(make_pair(32'h800000, 32'h7FFFFF, 32'hFFFF, 32'h0000, 32'hFFFF,
                                     32'h7FFFFF, 32'h800000, 32'h0000, 32'hFFFF, 32'hFFFF));
        directed.push_back(make_pair(32'h7FFFFF, 32'h7FFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                                     32'h7FFFFF, 32'h7FFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF));
        directed.push_back(make_pair(32'h800000, 32'h800000, 32'hFFFF, 32'hFFFF, 32'h0000,
                                     32'h800000, 32'h800000, 32'h0000, 32'h0000, 32'hFFFF));
        directed.push_back(make_pair(32'h7FFFFF, 32'h800000, 0, 0, 0,
                                     32'h800000, 32'h7FFFFF, 0, 0, 0));

        // Hold reset, then release it on a falling edge.
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) send_pair(directed[i]);

        // Random traffic with idling on both sides.
        repeat (500) send_pair(random_pair());

        // Long stretch at full rate: no idling at all.
        calm <= 1'b1;
        repeat (300) send_pair(random_pair());

        // Stall the receiver while requests keep coming, so the pipeline fills
        // and s_ready drops.
        hold_off_pending <= 1'b1;
        repeat (40) send_pair(random_pair());
        calm <= 1'b0;

        repeat (540) send_pair(random_pair());
        s_valid <= 1'b0;

        // Drain, then keep watching for any stray result.
        while (sb.expected_contacts.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("aabb_overlap_side_resolver_tb passed");
        end else begin
            $display("aabb_overlap_side_resolver_tb failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/aosr_pkg.sv
hdl/aosr_round_sat.sv
hdl/aabb_overlap_side_resolver.sv
hdl/aosr_checker.sv
verif/aabb_overlap_side_resolver_tb.sv
